/* rtl/smcq_pkg.sv */
// Shared types and constants for the sorted min-cost queue.
package smcq_pkg;

    localparam int unsigned DEPTH_DEFAULT    = 16;
    localparam int unsigned TAG_BITS_DEFAULT = 10;
    localparam int unsigned COST_W           = 8;
    localparam int unsigned TAG_FIELD_W      = 10;
    localparam int unsigned FILL_W           = 5;

    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } kind_t;

    typedef struct packed {
        logic                     kind;
        logic [COST_W-1:0]        new_cost;
        logic [TAG_FIELD_W-1:0]   node_tag;
    } req_t;

    typedef struct packed {
        logic [COST_W-1:0]        out_cost;
        logic [TAG_FIELD_W-1:0]   out_tag;
        logic                     out_valid;
        logic                     was_empty;
        logic                     overflowed;
        logic [FILL_W-1:0]        fill_count;
    } rsp_t;

    // Broadcast to every cell of the row in the cycle a word is accepted.
    typedef struct packed {
        logic                     push;
        logic                     pop;
        logic [COST_W-1:0]        cost;
        logic [TAG_FIELD_W-1:0]   tag;
    } cell_cmd_t;

endpackage

/* rtl/smcq_cell.sv */
// One compare-and-shift cell of the sorted queue row.
module smcq_cell #(
    parameter int unsigned TAG_W = smcq_pkg::TAG_BITS_DEFAULT
) (
    input  logic                          clk,
    input  smcq_pkg::cell_cmd_t           cmd,
    input  logic                          occupied,
    input  logic                          left_less,
    input  logic [smcq_pkg::COST_W-1:0]   left_cost,
    input  logic [TAG_W-1:0]              left_tag,
    input  logic [smcq_pkg::COST_W-1:0]   right_cost,
    input  logic [TAG_W-1:0]              right_tag,
    output logic                          less,
    output logic [smcq_pkg::COST_W-1:0]   cost,
    output logic [TAG_W-1:0]              tag
);

    logic [smcq_pkg::COST_W-1:0] cost_reg;
    logic [TAG_W-1:0]            tag_reg;
    logic [smcq_pkg::COST_W-1:0] cost_next;
    logic [TAG_W-1:0]            tag_next;

    // Held entries are sorted, so "less" is true over a prefix of the row.
    assign less = occupied && (cost_reg < cmd.cost);

    always_comb
    begin
        cost_next = cost_reg;
        tag_next  = tag_reg;
        if (cmd.push && !less)
        begin
            if (left_less)
            begin
                // insert point: new word lands here
                cost_next = cmd.cost;
                tag_next  = cmd.tag[TAG_W-1:0];
            end
            else
            begin
                cost_next = left_cost;
                tag_next  = left_tag;
            end
        end
        else if (cmd.pop)
        begin
            cost_next = right_cost;
            tag_next  = right_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        cost_reg <= cost_next;
        tag_reg  <= tag_next;
    end

    assign cost = cost_reg;
    assign tag  = tag_reg;

endmodule

/* rtl/sorted_min_cost_queue_top.sv */
// Top level of the sorted min-cost queue: cell row, fill count and result register.
// Sorted priority queue of (cost, tag) pairs held in a row of DEPTH compare-and-shift
// cells, cheapest entry at cell 0. On each accepted word (push or pop),
// every cell compares its cost with the pushed cost in parallel and either holds,
// takes the new entry, or takes its neighbor's entry, so one word is accepted per
// clock while the result register can be emptied. Among equal costs the newest push
// comes out first. A push to a full queue is dropped and flagged; a pop of an empty
// queue is flagged. Each word yields exactly one result word in the cycle after it is
// accepted, carrying the fill count after that word. No clearing pass after reset.
module sorted_min_cost_queue_top #(
    parameter int unsigned DEPTH    = smcq_pkg::DEPTH_DEFAULT,
    parameter int unsigned TAG_BITS = smcq_pkg::TAG_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  smcq_pkg::req_t     req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output smcq_pkg::rsp_t     rsp
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned TAG_W = (TAG_BITS < smcq_pkg::TAG_FIELD_W) ?
                                    TAG_BITS : smcq_pkg::TAG_FIELD_W;

    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       rsp_valid_reg;
    smcq_pkg::rsp_t             rsp_reg;
    smcq_pkg::rsp_t             rsp_next;
    smcq_pkg::cell_cmd_t        cmd;
    logic                       accept;
    logic                       full;
    logic                       empty;
    logic [CNT_W+smcq_pkg::FILL_W-1:0] fill_wide;

    logic [smcq_pkg::COST_W-1:0] cell_cost [DEPTH];
    logic [TAG_W-1:0]            cell_tag  [DEPTH];
    logic                        cell_less [DEPTH];

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        cmd.push = accept && (req.kind == smcq_pkg::KIND_PUSH) && !full;
        cmd.pop  = accept && (req.kind == smcq_pkg::KIND_POP) && !empty;
        cmd.cost = req.new_cost;
        cmd.tag  = req.node_tag;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                        l_less;
            logic [smcq_pkg::COST_W-1:0] l_cost;
            logic [TAG_W-1:0]            l_tag;
            logic [smcq_pkg::COST_W-1:0] r_cost;
            logic [TAG_W-1:0]            r_tag;

            if (gi == 0)
            begin : g_head
                assign l_less = 1'b1;
                assign l_cost = cell_cost[gi];
                assign l_tag  = cell_tag[gi];
            end
            else
            begin : g_body
                assign l_less = cell_less[gi-1];
                assign l_cost = cell_cost[gi-1];
                assign l_tag  = cell_tag[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign r_cost = cell_cost[gi];
                assign r_tag  = cell_tag[gi];
            end
            else
            begin : g_mid
                assign r_cost = cell_cost[gi+1];
                assign r_tag  = cell_tag[gi+1];
            end

            smcq_cell #(
                .TAG_W (TAG_W)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .occupied   (CNT_W'(gi) < count_reg),
                .left_less  (l_less),
                .left_cost  (l_cost),
                .left_tag   (l_tag),
                .right_cost (r_cost),
                .right_tag  (r_tag),
                .less       (cell_less[gi]),
                .cost       (cell_cost[gi]),
                .tag        (cell_tag[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // fill count field is the low bits of the count
    assign fill_wide = {{smcq_pkg::FILL_W{1'b0}}, count_next};

    always_comb
    begin
        rsp_next            = '0;
        rsp_next.fill_count = fill_wide[smcq_pkg::FILL_W-1:0];
        if (req.kind == smcq_pkg::KIND_PUSH)
        begin
            rsp_next.overflowed = full;
        end
        else if (empty)
        begin
            rsp_next.was_empty = 1'b1;
        end
        else
        begin
            rsp_next.out_valid = 1'b1;
            rsp_next.out_cost  = cell_cost[0];
            rsp_next.out_tag   = smcq_pkg::TAG_FIELD_W'(cell_tag[0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
